// ----- rtl/ibc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibc_pkg: shared types and constants of the IMU bias calibrator
// Calibration phases, controller states, register map and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ibc_pkg;

  // window register width and reset values
  localparam int unsigned CFG_W             = 16;
  localparam int unsigned APB_DATA_W        = 32;
  localparam int unsigned APB_ADDR_W        = 3;
  localparam logic [CFG_W-1:0] INITIAL_WIN_RST = 16'd256;
  localparam logic [CFG_W-1:0] RECAL_WIN_RST   = 16'd64;

  // register index (byte address / 4)
  localparam logic REG_INITIAL_WINDOW = 1'b0;
  localparam logic REG_RECAL_WINDOW   = 1'b1;

  // input word kind, carried on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_RECAL  = 1'b1;

  typedef enum logic [1:0] {
    PH_INITIAL = 2'd0,
    PH_RECAL   = 2'd1,
    PH_READY   = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_DIVIDE = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic sum_add;          // add the incoming sample, bump the count
    logic sum_clear;        // zero sums and count
    logic use_initial;      // compare against the initial window
    logic div_start;        // launch the three dividers
    logic bias_load;        // take the quotients as the new bias
    logic res_load;         // capture a result word
    logic res_accepted;
    logic res_done;
    logic res_was_initial;
    logic res_ready;
  } ibc_cmd_t;

  typedef struct packed {
    logic window_full;      // the sample on the input completes the window
    logic div_done;         // quotients valid this cycle
  } ibc_stat_t;

endpackage

// ----- rtl/ibc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibc_divider: three-lane serial signed-by-unsigned divider
// Restoring division, one quotient bit per cycle on all three axes at once,
// truncating toward zero. One shared step counter.
// ----------------------------------------------------------------------------
module ibc_divider #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0]    dividend_i [3],
  input  logic        [COUNT_WIDTH-1:0]                 divisor_i,
  output logic signed [SAMPLE_WIDTH-1:0]                quotient_o [3],
  output logic                                          done_o
);
  localparam int unsigned SUM_W  = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [COUNT_WIDTH-1:0] den_q, den_d;
  logic                   neg_q [3];
  logic                   neg_d [3];
  logic [SUM_W-1:0]       quo_q [3];
  logic [SUM_W-1:0]       quo_d [3];
  logic [COUNT_WIDTH-1:0] rem_q [3];
  logic [COUNT_WIDTH-1:0] rem_d [3];
  logic [COUNT_WIDTH:0]   rem_sh [3];
  logic [COUNT_WIDTH:0]   rem_diff [3];
  logic                   ge [3];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    den_d  = den_q;
    for (int k = 0; k < 3; k++) begin
      neg_d[k]    = neg_q[k];
      quo_d[k]    = quo_q[k];
      rem_d[k]    = rem_q[k];
      rem_sh[k]   = {rem_q[k], quo_q[k][SUM_W-1]};
      rem_diff[k] = rem_sh[k] - {1'b0, den_q};
      ge[k]       = (rem_sh[k] >= {1'b0, den_q});
    end
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      den_d  = divisor_i;
      for (int k = 0; k < 3; k++) begin
        neg_d[k] = dividend_i[k][SUM_W-1];
        quo_d[k] = dividend_i[k][SUM_W-1] ? SUM_W'(-dividend_i[k]) : SUM_W'(dividend_i[k]);
        rem_d[k] = '0;
      end
    end else if (busy_q) begin
      step_d = step_q + 1'b1;
      for (int k = 0; k < 3; k++) begin
        rem_d[k] = ge[k] ? rem_diff[k][COUNT_WIDTH-1:0] : rem_sh[k][COUNT_WIDTH-1:0];
        quo_d[k] = {quo_q[k][SUM_W-2:0], ge[k]};
      end
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    for (int k = 0; k < 3; k++) begin
      neg_q[k] <= neg_d[k];
      quo_q[k] <= quo_d[k];
      rem_q[k] <= rem_d[k];
    end
  end

  // magnitude never exceeds 2^(SAMPLE_WIDTH-1), so the low bits suffice
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quotient_o[k] = neg_q[k] ? -signed'(quo_q[k][SAMPLE_WIDTH-1:0])
                               : signed'(quo_q[k][SAMPLE_WIDTH-1:0]);
    end
  end

  assign done_o = done_q;

endmodule

// ----- rtl/ibc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibc_datapath: accumulators, window compare, divider and result register
// Runs on commands from ibc_ctrl and reports window and divider status.
// ----------------------------------------------------------------------------
module ibc_datapath #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ibc_pkg::ibc_cmd_t                 cmd_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    accel_z_i,
  input  logic [ibc_pkg::CFG_W-1:0]         win_initial_i,
  input  logic [ibc_pkg::CFG_W-1:0]         win_recal_i,
  output ibc_pkg::ibc_stat_t                stat_o,
  output logic [4+3*SAMPLE_WIDTH-1:0]       res_o
);
  import ibc_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int unsigned RES_W = 4 + 3 * SAMPLE_WIDTH;

  logic [COUNT_WIDTH-1:0]         count_q;
  logic [COUNT_WIDTH:0]           count_inc;
  logic [COUNT_WIDTH-1:0]         win;
  logic [COUNT_WIDTH-1:0]         target;
  logic signed [SAMPLE_WIDTH-1:0] sample [3];
  logic signed [SUM_W-1:0]        sum_q [3];
  logic signed [SUM_W-1:0]        sum_next [3];
  logic signed [SAMPLE_WIDTH-1:0] quotient [3];
  logic signed [SAMPLE_WIDTH-1:0] bias_q [3];
  logic signed [SAMPLE_WIDTH-1:0] bias_d [3];
  logic                           div_done;
  logic [RES_W-1:0]               res_q;

  assign sample[0] = accel_x_i;
  assign sample[1] = accel_y_i;
  assign sample[2] = accel_z_i;

  // window taken modulo 2^COUNT_WIDTH, zero behaves as one
  assign win       = cmd_i.use_initial ? COUNT_WIDTH'(win_initial_i)
                                       : COUNT_WIDTH'(win_recal_i);
  assign target    = (win == '0) ? COUNT_WIDTH'(1) : win;
  assign count_inc = {1'b0, count_q} + 1'b1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_next[k] = sum_q[k] + SUM_W'(sample[k]);
      bias_d[k]   = cmd_i.bias_load ? quotient[k] : bias_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k]  <= '0;
        bias_q[k] <= '0;
      end
    end else begin
      if (cmd_i.sum_clear) begin
        count_q <= '0;
        for (int k = 0; k < 3; k++) sum_q[k] <= '0;
      end else if (cmd_i.sum_add) begin
        count_q <= count_inc[COUNT_WIDTH-1:0];
        for (int k = 0; k < 3; k++) sum_q[k] <= sum_next[k];
      end
      for (int k = 0; k < 3; k++) bias_q[k] <= bias_d[k];
    end
  end

  // divider sees the sums including the completing sample
  ibc_divider #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(sum_next),
    .divisor_i (count_inc[COUNT_WIDTH-1:0]),
    .quotient_o(quotient),
    .done_o    (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q <= {bias_d[2], bias_d[1], bias_d[0], cmd_i.res_ready,
                cmd_i.res_was_initial, cmd_i.res_done, cmd_i.res_accepted};
    end
  end

  assign stat_o.window_full = (count_inc >= {1'b0, target});
  assign stat_o.div_done    = div_done;
  assign res_o              = res_q;

endmodule

// ----- rtl/ibc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibc_ctrl: calibration controller
// Tracks the calibration phase, decides what each word does and holds the
// output valid flag.
// ----------------------------------------------------------------------------
module ibc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ibc_pkg::ibc_cmd_t   cmd_o,
  input  ibc_pkg::ibc_stat_t  stat_i
);
  import ibc_pkg::*;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic        first_q, first_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_INITIAL;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    first_d    = first_q;
    cmd_o      = '0;
    cmd_o.use_initial = (phase_q == PH_INITIAL);
    in_ready_o = 1'b0;
    accept     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          if (in_kind_i == CMD_RECAL) begin
            if (phase_q == PH_READY) begin
              phase_d         = PH_RECAL;
              cmd_o.sum_clear = 1'b1;
            end
            cmd_o.res_load = 1'b1;
          end else if (phase_q == PH_READY) begin
            // sample while ready: rejected, nothing changes
            cmd_o.res_load  = 1'b1;
            cmd_o.res_ready = 1'b1;
          end else begin
            cmd_o.sum_add = 1'b1;
            if (stat_i.window_full) begin
              cmd_o.div_start = 1'b1;
              first_d         = (phase_q == PH_INITIAL);
              state_d         = ST_DIVIDE;
            end else begin
              cmd_o.res_load     = 1'b1;
              cmd_o.res_accepted = 1'b1;
            end
          end
        end
      end
      ST_DIVIDE: begin
        if (stat_i.div_done) begin
          cmd_o.bias_load       = 1'b1;
          cmd_o.sum_clear       = 1'b1;
          cmd_o.res_load        = 1'b1;
          cmd_o.res_accepted    = 1'b1;
          cmd_o.res_done        = 1'b1;
          cmd_o.res_was_initial = first_q;
          cmd_o.res_ready       = 1'b1;
          phase_d               = PH_READY;
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = cmd_o.res_load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/imu_bias_calibrator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_calibrator_unit: three-axis accelerometer bias calibrator
// Block-averages x/y/z samples over a programmable window and holds the
// resulting bias; recalibration on command.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake               payload
//  --------  ----  ----------------------  ------------------------------------
//  s_axis    in    tvalid / tready         tuser: cmd; tdata: accel x, y, z
//  m_axis    out   tvalid / tready         tdata: flags, bias x, y, z
//  apb       in    psel/penable/pready     initial_window @0x0, recal_window @0x4
//
//  A word that does not close a window yields its result in the cycle after it
//  is taken. A sample that closes a window starts the three serial dividers,
//  which produce one quotient bit per cycle; its result is registered once
//  the dividers report done.
//  One word is in work at a time; s_axis_tready is low while the dividers
//  run, and a result waiting in the output register holds s_axis off until
//  m_axis takes it (the next word can go in at that same edge).
//  Reset: initial phase, sums, count and bias zero, windows 256 and 64.
//
module imu_bias_calibrator_unit #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: accel_x, accel_y, accel_z (lowest first), zero padded to bytes
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser: cmd (0 sample, 1 recalibrate)
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: accepted, done_res, was_initial, ready_res, bias_out_x,
  //        bias_out_y, bias_out_z (lowest first), zero padded to bytes
  output logic [((4+3*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ibc_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ibc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ibc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import ibc_pkg::*;

  localparam int unsigned OUT_TDATA_W = ((4 + 3 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned RES_W       = 4 + 3 * SAMPLE_WIDTH;

  logic [CFG_W-1:0] win_initial_q;
  logic [CFG_W-1:0] win_recal_q;
  logic             reg_idx;
  logic             cfg_wr;
  ibc_cmd_t         cmd;
  ibc_stat_t        stat;
  logic [RES_W-1:0] res;

  // --- register port: no wait states, written in the access phase ---
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_initial_q <= INITIAL_WIN_RST;
      win_recal_q   <= RECAL_WIN_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INITIAL_WINDOW: win_initial_q <= pwdata[CFG_W-1:0];
        REG_RECAL_WINDOW:   win_recal_q   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INITIAL_WINDOW: prdata = APB_DATA_W'(win_initial_q);
      REG_RECAL_WINDOW:   prdata = APB_DATA_W'(win_recal_q);
      default:            prdata = '0;
    endcase
  end

  // --- controller: phase tracking and handshakes ---
  ibc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // --- datapath: sums, count, dividers, bias and result word ---
  ibc_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .accel_x_i    (signed'(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .accel_y_i    (signed'(s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .accel_z_i    (signed'(s_axis_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH])),
    .win_initial_i(win_initial_q),
    .win_recal_i  (win_recal_q),
    .stat_o       (stat),
    .res_o        (res)
  );

  // result word zero extended to whole bytes
  assign m_axis_tdata = OUT_TDATA_W'(res);

endmodule

// ----- tb/sv/tb_imu_bias_calibrator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_bias_calibrator_unit: self-checking bench for the IMU bias calibrator
// Streams sample and recalibrate words into the block under random stalls on
// both sides, predicts each result word from its own model of the window
// averaging and checks the results in order, field by field. The window
// registers are reprogrammed over APB between test phases, while idle.
// ----------------------------------------------------------------------------
module tb_imu_bias_calibrator_unit;
  import ibc_pkg::*;

  localparam int unsigned SW    = 16;
  localparam int unsigned CW    = 16;
  localparam int unsigned IN_W  = ((3*SW+7)/8)*8;
  localparam int unsigned OUT_W = ((4+3*SW+7)/8)*8;
  // settle time past the slowest result; leave plenty of margin
  localparam int unsigned SETTLE_CYCLES = 2*(SW+CW+2) + 10;

  typedef struct {
    logic        cmd;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } imu_word_t;

  typedef struct packed {
    logic        accepted;
    logic        done;
    logic        was_initial;
    logic        ready;
    logic [15:0] bx;
    logic [15:0] by;
    logic [15:0] bz;
  } bias_word_t;

  // --------------------------------------------------------------------------
  // DUT signals: every input known from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic                  s_axis_tuser  = CMD_SAMPLE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  imu_bias_calibrator_unit #(
    .SAMPLE_WIDTH(SW),
    .COUNT_WIDTH (CW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  imu_word_t  pending_words[$];    // words waiting for the driver
  bias_word_t pending_results[$];  // predicted result words, oldest first

  logic word_taken = 1'b0;   // input word went across at the last rising edge
  bit   calm       = 1'b0;   // no idling on either side while set
  int   errors     = 0;
  int   words_queued = 0;
  int   words_sent   = 0;
  int   results_seen = 0;
  int   passes_done  = 0;
  int   initial_passes = 0;
  int   hold_left  = 0;
  bit   hold_done  = 1'b0;

  // calibrator model: configuration copy and running state
  logic [15:0] win_init  = INITIAL_WIN_RST;
  logic [15:0] win_recal = RECAL_WIN_RST;
  phase_e      cal_phase = PH_INITIAL;
  int          cnt       = 0;
  longint      sum_x     = 0;
  longint      sum_y     = 0;
  longint      sum_z     = 0;
  logic [15:0] bias_x    = '0;
  logic [15:0] bias_y    = '0;
  logic [15:0] bias_z    = '0;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Model of the block average
  // --------------------------------------------------------------------------
  function automatic void clear_sums();
    cnt   = 0;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
  endfunction

  // Advances the model by one input word and queues the result it yields.
  task automatic predict_calibration(input logic cmd, input logic [15:0] ax,
                                     input logic [15:0] ay, input logic [15:0] az);
    bias_word_t r;
    logic       first;
    int         target;
    r = '0;
    if (cmd == CMD_RECAL) begin
      // only honored once a pass is complete; ignored mid-pass
      if (cal_phase == PH_READY) begin
        cal_phase = PH_RECAL;
        clear_sums();
      end
    end else if (cal_phase != PH_READY) begin
      first  = (cal_phase == PH_INITIAL);
      target = first ? int'(win_init) : int'(win_recal);
      if (target == 0) target = 1;  // zero window behaves as one
      r.accepted = 1'b1;
      sum_x += longint'($signed(ax));
      sum_y += longint'($signed(ay));
      sum_z += longint'($signed(az));
      cnt++;
      // ">=" so a window lowered mid-pass closes at the next sample;
      // divide by the samples actually summed, truncating toward zero
      if (cnt >= target) begin
        bias_x    = 16'(sum_x / cnt);
        bias_y    = 16'(sum_y / cnt);
        bias_z    = 16'(sum_z / cnt);
        cal_phase = PH_READY;
        clear_sums();
        r.done        = 1'b1;
        r.was_initial = first;
      end
    end
    r.ready = (cal_phase == PH_READY);
    r.bx    = bias_x;
    r.by    = bias_y;
    r.bz    = bias_z;
    pending_results.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: changes on the falling edge, one word in flight
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    imu_word_t nxt;
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
        nxt = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.cmd;
        s_axis_tdata  <= {nxt.z, nxt.y, nxt.x};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side ready: random stalls, plus one long hold-off so the block
  // backs up and has to stall its input while the driver keeps offering.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && words_sent >= 650) begin
      hold_done = 1'b1;
      hold_left = 200;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 12);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : mon
    bias_word_t want;
    bias_word_t got;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        // tdata: accepted, done, was_initial, ready, bias x, y, z from bit 0
        got.accepted    = m_axis_tdata[0];
        got.done        = m_axis_tdata[1];
        got.was_initial = m_axis_tdata[2];
        got.ready       = m_axis_tdata[3];
        got.bx          = m_axis_tdata[19:4];
        got.by          = m_axis_tdata[35:20];
        got.bz          = m_axis_tdata[51:36];
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result word, expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("accepted",    want.accepted,    got.accepted);
          check_field("done_res",    want.done,        got.done);
          check_field("was_initial", want.was_initial, got.was_initial);
          check_field("ready_res",   want.ready,       got.ready);
          check_field("bias_out_x",  $signed(want.bx), $signed(got.bx));
          check_field("bias_out_y",  $signed(want.by), $signed(got.by));
          check_field("bias_out_z",  $signed(want.bz), $signed(got.bz));
          if (want.done) passes_done++;
          if (want.was_initial) initial_passes++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        words_sent++;
        predict_calibration(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                            s_axis_tdata[47:32]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register access
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // register only keeps the low 16 bits
    if (idx == REG_INITIAL_WINDOW) win_init = val[15:0];
    else win_recal = val[15:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic idx, input logic [15:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'h0000, want}) begin
      errors++;
      $display("%0t ns: register %0d readback mismatch, expected %h, actual %h",
               $time, idx, {16'h0000, want}, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // biased toward the axis extremes, otherwise uniform
  function automatic logic [15:0] rand_axis();
    case ($urandom_range(15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic cmd, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    imu_word_t w;
    w.cmd = cmd;
    w.x   = x;
    w.y   = y;
    w.z   = z;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_sample();
    push_word(CMD_SAMPLE, rand_axis(), rand_axis(), rand_axis());
  endtask

  task automatic push_recal();
    push_word(CMD_RECAL, rand_axis(), rand_axis(), rand_axis());
  endtask

  // One recalibration pass: the command, then a window of samples. Now and
  // then a stray recal lands mid-pass, the pass runs one short or long, or a
  // sample arrives while the block is ready.
  task automatic push_pass();
    int n;
    n = (win_recal == 0) ? 1 : int'(win_recal);
    if ($urandom_range(99) < 15) n = n + $urandom_range(2) - 1;
    push_recal();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) push_recal();
      push_sample();
    end
    if ($urandom_range(99) < 10) push_sample();
  endtask

  // idle: nothing queued, nothing on the wire, no result outstanding
  task automatic wait_drained();
    while (pending_words.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_start;
    logic [31:0] rw;
    @(posedge rst_ni);
    repeat (2) @(posedge clk_i);

    check_reg(REG_INITIAL_WINDOW, INITIAL_WIN_RST);
    check_reg(REG_RECAL_WINDOW, RECAL_WIN_RST);

    // initial pass at the reset window: recal is ignored, extremes summed
    push_recal();
    push_word(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    push_word(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h0000);
    wait_drained();

    // lower the initial window below the count (upper bits must be dropped);
    // a zero recal window acts as one
    apb_write(REG_INITIAL_WINDOW, 32'hFFFF_0002);
    apb_write(REG_RECAL_WINDOW, 32'h0000_0000);
    push_word(CMD_SAMPLE, 16'hFFFF, 16'h0001, 16'h8000);  // closes the initial pass
    push_sample();                                        // ignored while ready
    push_recal();
    push_recal();                                         // ignored mid-pass
    push_word(CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_recal();
    push_word(CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'h1234);
    wait_drained();

    // widest windows, then shrink one mid-pass so a long sum gets divided
    apb_write(REG_INITIAL_WINDOW, 32'h0000_FFFF);
    apb_write(REG_RECAL_WINDOW, 32'h0000_FFFF);
    check_reg(REG_INITIAL_WINDOW, 16'hFFFF);
    check_reg(REG_RECAL_WINDOW, 16'hFFFF);
    push_recal();
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0) push_word(CMD_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000);
      else push_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h7FFF);
    end
    wait_drained();
    apb_write(REG_RECAL_WINDOW, 32'h0000_0003);
    push_sample();
    push_sample();
    wait_drained();

    // random phases, each with its own windows
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: rw = 32'h0000_0001;
        1: rw = $urandom_range(2, 12);
        2: rw = 32'h0000_0005;
        3: rw = 32'h0003_0007;       // only the low half counts
        4: rw = 32'h0000_0028;
        default: rw = $urandom_range(1, 16);
      endcase
      apb_write(REG_RECAL_WINDOW, rw);
      apb_write(REG_INITIAL_WINDOW, $urandom);
      calm = (ph == 2);              // one stretch with no idling at all
      phase_start = words_queued;
      while (words_queued - phase_start < 150) push_pass();
      wait_drained();
      calm = 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d words (samples and recal commands) through the calibrator, %0d results",
             words_sent, results_seen);
    $display("checked; %0d passes closed, %0d of them initial, windows 0 to 65535.",
             passes_done, initial_passes);
    if (errors == 0) begin
      $display("** imu_bias_calibrator_unit: PASSED **");
    end else begin
      $display("** imu_bias_calibrator_unit: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("** imu_bias_calibrator_unit: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ibc_pkg.sv
rtl/ibc_divider.sv
rtl/ibc_datapath.sv
rtl/ibc_ctrl.sv
rtl/imu_bias_calibrator_unit.sv
tb/sv/tb_imu_bias_calibrator_unit.sv
